// ----- rtl/core/lfn_entry_framer_top_assert.svh -----
// Assertion macros for the long-name entry framer checker.
`ifndef LFN_ENTRY_FRAMER_TOP_ASSERT_SVH
`define LFN_ENTRY_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LFN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LFN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lfn_pkg.sv -----
// ----------------------------------------------------------------------------
// lfn_pkg
// Shared constants and types of the long-name entry framer.
// ----------------------------------------------------------------------------
package lfn_pkg;

	localparam int SLOTS       = 13;
	localparam int MAX_ENTRIES = 20;
	localparam int POS_W       = 4;
	localparam int ENT_W       = 5;
	localparam int UNIT_W      = 16;

	localparam logic [6:0]        LAST_FLAG = 7'h40;
	localparam logic [UNIT_W-1:0] PAD_UNIT  = 16'hFFFF;
	localparam logic [UNIT_W-1:0] TERM_UNIT = 16'h0000;

	localparam logic CMD_UNIT  = 1'b0;
	localparam logic CMD_EMPTY = 1'b1;

	// Per-cycle control broadcast to the row of slot cells.
	typedef struct packed {
		logic              wr_en;
		logic [POS_W-1:0]  wr_pos;
		logic [UNIT_W-1:0] wr_unit;
		logic              load;
		logic [POS_W-1:0]  fill;
		logic              shift;
	} cell_ctl_t;

endpackage

// ----- rtl/core/lfn_cell.sv -----
// ----------------------------------------------------------------------------
// lfn_cell
// One character slot: assembly register plus one stage of the output chain.
// ----------------------------------------------------------------------------
module lfn_cell
	import lfn_pkg::*;
(
	input  logic              clk,
	input  logic [POS_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [UNIT_W-1:0] nxt_unit,
	output logic [UNIT_W-1:0] out_unit
);

	logic [UNIT_W-1:0] asm_q;
	logic [UNIT_W-1:0] out_q;
	logic [UNIT_W-1:0] ld_unit;
	logic              hit;

	assign hit = ctl.wr_en && (ctl.wr_pos == idx);

	// Slots below fill carry name units (bypass the one written this beat),
	// the slot at fill gets the terminator, the rest padding.
	always_comb begin
		if (idx < ctl.fill) begin
			ld_unit = hit ? ctl.wr_unit : asm_q;
		end else if (idx == ctl.fill) begin
			ld_unit = TERM_UNIT;
		end else begin
			ld_unit = PAD_UNIT;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			asm_q <= ctl.wr_unit;
		end
		if (ctl.load) begin
			out_q <= ld_unit;
		end else if (ctl.shift) begin
			out_q <= nxt_unit;
		end
	end

	assign out_unit = out_q;

endmodule

// ----- rtl/core/lfn_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfn_ctrl
// Name state, entry rollover and drain count of the output chain.
// ----------------------------------------------------------------------------
module lfn_ctrl
	import lfn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [UNIT_W-1:0] code_unit,
	input  logic             is_final,
	input  logic [7:0]       short_checksum,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [6:0]       order_byte,
	output logic [POS_W-1:0] slot_index,
	output logic [7:0]       entry_checksum,
	output logic             end_of_entry,
	output logic             too_long,
	output cell_ctl_t        ctl
);

	logic [POS_W-1:0] pos_q;
	logic [ENT_W-1:0] ent_q;
	logic [7:0]       hcks_q;
	logic             drop_q;
	logic [POS_W-1:0] cnt_q;
	logic [6:0]       ord_q;
	logic [7:0]       ocks_q;
	logic             otl_q;

	logic             name_start, full, is_empty, last, roll, emit;
	logic             load_free, acc, pop, drop_nx;
	logic [7:0]       cks_eff;
	logic [POS_W-1:0] pos_nx;
	logic [ENT_W:0]   ent_inc;

	always_comb begin
		name_start = (pos_q == '0) && (ent_q == '0);
		cks_eff    = name_start ? short_checksum : hcks_q;
		full       = (pos_q == POS_W'(SLOTS));
		pos_nx     = full ? pos_q : pos_q + 1'b1;
		drop_nx    = drop_q | full;
		ent_inc    = {1'b0, ent_q} + 1'b1;
		is_empty   = (cmd == CMD_EMPTY);
		last       = is_empty | is_final;
		roll       = (pos_nx == POS_W'(SLOTS)) && (ent_inc < (ENT_W + 1)'(MAX_ENTRIES));
		emit       = last | roll;
		// Chain takes a new entry when empty or when its last beat leaves now.
		load_free  = (cnt_q == '0) || ((cnt_q == POS_W'(1)) && out_ready);
		in_ready   = !emit || load_free;
		acc        = in_valid && in_ready;
		pop        = out_valid && out_ready;

		ctl.wr_en   = acc && !is_empty && !full;
		ctl.wr_pos  = pos_q;
		ctl.wr_unit = code_unit;
		ctl.load    = acc && emit;
		ctl.shift   = pop && !(acc && emit);
		if (is_empty) begin
			ctl.fill = '0;
		end else if (last) begin
			ctl.fill = pos_nx;
		end else begin
			ctl.fill = POS_W'(SLOTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ent_q  <= '0;
			hcks_q <= '0;
			drop_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (acc) begin
				if (last) begin
					pos_q  <= '0;
					ent_q  <= '0;
					hcks_q <= '0;
					drop_q <= 1'b0;
				end else if (roll) begin
					pos_q  <= '0;
					ent_q  <= ent_inc[ENT_W-1:0];
					hcks_q <= cks_eff;
					drop_q <= drop_nx;
				end else begin
					pos_q  <= pos_nx;
					hcks_q <= cks_eff;
					drop_q <= drop_nx;
				end
			end
			if (ctl.load) begin
				cnt_q <= POS_W'(SLOTS);
			end else if (pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry-wide fields, held while the chain drains.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ord_q  <= (last ? LAST_FLAG : 7'h00) | {1'b0, is_empty ? 6'd1 : ent_inc};
			ocks_q <= is_empty ? short_checksum : cks_eff;
			otl_q  <= !is_empty && is_final && drop_nx;
		end
	end

	assign out_valid      = (cnt_q != '0);
	assign order_byte     = ord_q;
	assign slot_index     = POS_W'(SLOTS) - cnt_q;
	assign entry_checksum = ocks_q;
	assign end_of_entry   = (cnt_q == POS_W'(1));
	assign too_long       = otl_q;

endmodule

// ----- rtl/core/lfn_entry_framer_top.sv -----
// ----------------------------------------------------------------------------
// lfn_entry_framer_top
// Packs long-name code units into 13-slot directory entries, one slot a beat.
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  in      | in_valid/in_ready, cmd, code_unit,        | one code unit or
//          | is_final, short_checksum                  | an empty-name command
//  out     | out_valid/out_ready, order_byte,          | one slot of an entry
//          | slot_index, slot_unit, entry_checksum,    |
//          | end_of_entry, too_long                    |
//
// One input beat per cycle; the beat that completes an entry loads the row of
// 13 slot cells, and slot 0 is on the output in the next cycle. The entry then
// leaves as 13 output beats, one per cycle, shifted along the row.
// A beat that completes an entry waits until the last slot of the previous
// entry leaves (same cycle at the earliest); other beats are taken at once.
// Reset clears name state and the drain count; slot storage needs no clearing.
// Output stalls hold the chain; input keeps filling the assembly registers.
// ----------------------------------------------------------------------------
module lfn_entry_framer_top
	import lfn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [UNIT_W-1:0] code_unit,
	input  logic              is_final,
	input  logic [7:0]        short_checksum,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [6:0]        order_byte,
	output logic [POS_W-1:0]  slot_index,
	output logic [UNIT_W-1:0] slot_unit,
	output logic [7:0]        entry_checksum,
	output logic              end_of_entry,
	output logic              too_long
);

	cell_ctl_t         ctl;
	logic [UNIT_W-1:0] chain_w [SLOTS];

	lfn_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.code_unit      (code_unit),
		.is_final       (is_final),
		.short_checksum (short_checksum),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.order_byte     (order_byte),
		.slot_index     (slot_index),
		.entry_checksum (entry_checksum),
		.end_of_entry   (end_of_entry),
		.too_long       (too_long),
		.ctl            (ctl)
	);

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		logic [UNIT_W-1:0] nxt;
		if (k == SLOTS - 1) begin : g_tail
			assign nxt = PAD_UNIT;
		end else begin : g_body
			assign nxt = chain_w[k+1];
		end
		lfn_cell u_cell (
			.clk      (clk),
			.idx      (POS_W'(k)),
			.ctl      (ctl),
			.nxt_unit (nxt),
			.out_unit (chain_w[k])
		);
	end

	// Head of the chain is the slot on the output.
	assign slot_unit = chain_w[0];

endmodule

// ----- rtl/core/lfn_chk.sv -----
// ----------------------------------------------------------------------------
// lfn_chk
// Port-level checks of the long-name entry framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfn_entry_framer_top_assert.svh"

module lfn_chk
	import lfn_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              cmd,
	input logic [UNIT_W-1:0] code_unit,
	input logic              is_final,
	input logic [7:0]        short_checksum,
	input logic              out_valid,
	input logic              out_ready,
	input logic [6:0]        order_byte,
	input logic [POS_W-1:0]  slot_index,
	input logic [UNIT_W-1:0] slot_unit,
	input logic [7:0]        entry_checksum,
	input logic              end_of_entry,
	input logic              too_long
);

	// Slots of one entry leave without gaps and in order.
	`LFN_ASSERT_NEXT(a_slot_run, out_valid && out_ready && !end_of_entry, out_valid && (slot_index == $past(slot_index) + 1'b1), "entry slots not contiguous")

	// A stalled slot beat holds its unit.
	`LFN_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(slot_unit) && $stable(slot_index), "stalled slot changed")

	// Sequence number is never zero.
	`LFN_ASSERT_NOW(a_order, out_valid, order_byte[5:0] != 6'd0, "order byte without sequence")

	// Dropped units are only reported on a final entry.
	`LFN_ASSERT_NOW(a_too_long, out_valid && too_long, order_byte[6], "too_long on non-final entry")

endmodule

bind lfn_entry_framer_top lfn_chk u_chk (.*);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the long-name entry framer against a slot-level predictor.
// A short table of directed beats covers empty names, single-unit names,
// an abandoned name and an exactly full entry. Random names of mixed length
// follow. Every output beat is compared field by field with the oldest
// predicted slot. Both channels idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import lfn_pkg::*;

	localparam int PERIOD       = 8;
	localparam int RESET_CYCLES = 11;
	localparam int IDLE_PCT     = 23;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int TIMEOUT      = 4000000;

	// One input beat plus an optional typed-in expectation.
	typedef struct packed {
		logic              cmd;
		logic [UNIT_W-1:0] unit;
		logic              fin;
		logic [7:0]        cks;
		logic              typed;
		logic [6:0]        t_order;
		logic [POS_W-1:0]  t_term;
	} name_beat_t;

	typedef struct packed {
		logic [6:0]        order;
		logic [POS_W-1:0]  idx;
		logic [UNIT_W-1:0] unit;
		logic [7:0]        cks;
		logic              eoe;
		logic              tl;
	} slot_beat_t;

	localparam int DIR_N = 22;
	localparam name_beat_t DIR_TAB [DIR_N] = '{
		'{CMD_EMPTY, 16'h1234, 1'b1, 8'h00, 1'b1, 7'h41, 4'd0},
		'{CMD_UNIT,  16'h0000, 1'b1, 8'hFF, 1'b1, 7'h41, 4'd1},
		'{CMD_UNIT,  16'hFFFF, 1'b1, 8'h5A, 1'b1, 7'h41, 4'd1},
		'{CMD_EMPTY, 16'hFFFF, 1'b0, 8'hFF, 1'b1, 7'h41, 4'd0},
		// partial name, then an empty name drops it
		'{CMD_UNIT,  16'hAAAA, 1'b0, 8'h11, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h5555, 1'b0, 8'h22, 1'b0, 7'h00, 4'd0},
		'{CMD_EMPTY, 16'h0001, 1'b1, 8'h33, 1'b1, 7'h41, 4'd0},
		// final unit lands in slot 12: no terminator, no padding
		'{CMD_UNIT,  16'h0041, 1'b0, 8'hC3, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0042, 1'b0, 8'h3C, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0043, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0044, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0045, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0046, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0047, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0048, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h0049, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h004A, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h004B, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h004C, 1'b0, 8'h00, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'hD83D, 1'b1, 8'h00, 1'b0, 7'h00, 4'd0},
		// checksum is sampled on the first unit only
		'{CMD_UNIT,  16'h8001, 1'b0, 8'h80, 1'b0, 7'h00, 4'd0},
		'{CMD_UNIT,  16'h7FFE, 1'b1, 8'h01, 1'b0, 7'h00, 4'd0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic [UNIT_W-1:0] code_unit;
	logic              is_final;
	logic [7:0]        short_checksum;
	logic              out_valid;
	logic              out_ready;
	logic [6:0]        order_byte;
	logic [POS_W-1:0]  slot_index;
	logic [UNIT_W-1:0] slot_unit;
	logic [7:0]        entry_checksum;
	logic              end_of_entry;
	logic              too_long;

	name_beat_t cur_beat;
	slot_beat_t pending_slots [$];

	// predictor state of the name being packed
	logic [UNIT_W-1:0] name_units [SLOTS];
	int                fill_pos;
	int                entry_idx;
	logic [7:0]        name_cks;
	bit                units_dropped;

	int  n_errors;
	int  beats_sent;
	int  beats_in;
	int  slots_out;
	int  entries_out;
	int  truncated_out;
	int  hold_asks;
	bit  calm;

	lfn_entry_framer_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.code_unit      (code_unit),
		.is_final       (is_final),
		.short_checksum (short_checksum),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.order_byte     (order_byte),
		.slot_index     (slot_index),
		.slot_unit      (slot_unit),
		.entry_checksum (entry_checksum),
		.end_of_entry   (end_of_entry),
		.too_long       (too_long)
	);

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	task automatic clear_name();
		fill_pos      = 0;
		entry_idx     = 0;
		name_cks      = 8'h00;
		units_dropped = 1'b0;
	endtask

	// Build the 13 slots of the buffered entry; queue them only when keep is set.
	task automatic ship_entry(input int fill, input bit last, input bit keep);
		slot_beat_t s;
		for (int k = 0; k < SLOTS; k++) begin
			s.order = 7'((entry_idx + 1) & 'h3F) | (last ? LAST_FLAG : 7'h00);
			s.idx   = POS_W'(k);
			if (k < fill)
				s.unit = name_units[POS_W'(k)];
			else if (k == fill)
				s.unit = TERM_UNIT;
			else
				s.unit = PAD_UNIT;
			s.cks = name_cks;
			s.eoe = (k == SLOTS - 1);
			s.tl  = last & units_dropped;
			if (keep)
				pending_slots.push_back(s);
		end
	endtask

	task automatic frame_beat(input name_beat_t b, input bit keep);
		if (b.cmd == CMD_EMPTY) begin
			clear_name();
			name_cks = b.cks;
			ship_entry(0, 1'b1, keep);
			clear_name();
		end else begin
			if (fill_pos == 0 && entry_idx == 0)
				name_cks = b.cks;
			if (fill_pos >= SLOTS) begin
				units_dropped = 1'b1;
			end else begin
				name_units[POS_W'(fill_pos)] = b.unit;
				fill_pos++;
			end
			if (b.fin) begin
				ship_entry(fill_pos, 1'b1, keep);
				clear_name();
			end else if (fill_pos >= SLOTS && entry_idx + 1 < MAX_ENTRIES) begin
				ship_entry(SLOTS, 1'b0, keep);
				entry_idx++;
				fill_pos = 0;
			end
		end
	endtask

	// Single-entry final name whose slots before the terminator all hold b.unit.
	task automatic expect_typed(input name_beat_t b);
		slot_beat_t s;
		for (int k = 0; k < SLOTS; k++) begin
			s.order = b.t_order;
			s.idx   = POS_W'(k);
			s.unit  = (k < b.t_term) ? b.unit : ((k == b.t_term) ? TERM_UNIT : PAD_UNIT);
			s.cks   = b.cks;
			s.eoe   = (k == SLOTS - 1);
			s.tl    = 1'b0;
			pending_slots.push_back(s);
		end
	endtask

	task automatic cmp_field(input string what, input int want, input int got);
		if (want != got) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	task automatic check_slot(input slot_beat_t got);
		slot_beat_t want;
		if (pending_slots.size() == 0) begin
			n_errors++;
			$display("%0t: unexpected slot beat, expected none, actual %h", $time, got);
		end else begin
			want = pending_slots.pop_front();
			cmp_field("order_byte", int'(want.order), int'(got.order));
			cmp_field("slot_index", int'(want.idx), int'(got.idx));
			cmp_field("slot_unit", int'(want.unit), int'(got.unit));
			cmp_field("entry_checksum", int'(want.cks), int'(got.cks));
			cmp_field("end_of_entry", int'(want.eoe), int'(got.eoe));
			cmp_field("too_long", int'(want.tl), int'(got.tl));
		end
		slots_out++;
		if (got.eoe) begin
			entries_out++;
			if (got.tl)
				truncated_out++;
		end
	endtask

	// Predict on input beats and check output beats in one process, so that
	// the order of the two is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				beats_in++;
				if (cur_beat.typed) begin
					frame_beat(cur_beat, 1'b0);
					expect_typed(cur_beat);
				end else begin
					frame_beat(cur_beat, 1'b1);
				end
			end
			if (out_valid && out_ready)
				check_slot({order_byte, slot_index, slot_unit, entry_checksum,
					end_of_entry, too_long});
		end
	end

	// Receiver: random stalls, none while calm, and a long hold-off on request.
	initial begin
		int hold_done;
		hold_done = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asks != hold_done) begin
				hold_done = hold_asks;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic send_beat(input name_beat_t b);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= b.cmd;
		code_unit      <= b.unit;
		is_final       <= b.fin;
		short_checksum <= b.cks;
		cur_beat       <= b;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// len units with random content; an abandoned name is cut off by an
	// empty-name command instead of a final unit.
	task automatic send_name(input int len, input bit abandon);
		name_beat_t b;
		b = '0;
		for (int i = 0; i < len; i++) begin
			b.cmd  = CMD_UNIT;
			b.unit = UNIT_W'($urandom_range(0, 65535));
			b.fin  = (i == len - 1) && !abandon;
			b.cks  = 8'($urandom_range(0, 255));
			send_beat(b);
		end
		if (len == 0 || abandon) begin
			b.cmd  = CMD_EMPTY;
			b.unit = UNIT_W'($urandom_range(0, 65535));
			b.fin  = 1'($urandom_range(0, 1));
			b.cks  = 8'($urandom_range(0, 255));
			send_beat(b);
		end
	endtask

	task automatic random_names(input int n_items);
		int first;
		int len;
		int pick;
		first = beats_sent;
		while (beats_sent - first < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 0;
			else if (pick < 35)
				len = $urandom_range(SLOTS - 1, SLOTS + 1);
			else if (pick < 45)
				len = $urandom_range(2 * SLOTS - 1, 2 * SLOTS + 1);
			else
				len = $urandom_range(1, 20);
			send_name(len, $urandom_range(0, 99) < 12);
		end
	endtask

	// Drop valid and wait for every predicted slot to come out.
	task automatic drain_all();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_slots.size() != 0);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = CMD_UNIT;
		code_unit      = '0;
		is_final       = 1'b0;
		short_checksum = 8'h00;
		cur_beat       = '0;
		calm           = 1'b0;
		hold_asks      = 0;
		n_errors       = 0;
		beats_sent     = 0;
		beats_in       = 0;
		slots_out      = 0;
		entries_out    = 0;
		truncated_out  = 0;
		clear_name();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_beat(DIR_TAB[i]);

		// long receiver hold-off while names keep coming
		hold_asks++;
		random_names(35);
		calm = 1'b1;
		random_names(25);
		calm = 1'b0;
		drain_all();

		random_names(25);
		drain_all();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d input beats and %0d checked slot beats", beats_in, slots_out);
		$display("%0d entries framed, %0d of them truncated at the entry limit",
			entries_out, truncated_out);
		if (n_errors == 0)
			$display("** lfn_entry_framer_top: PASSED **");
		else
			$display("** lfn_entry_framer_top: FAILED **");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("timeout with %0d slot beats outstanding", pending_slots.size());
		$display("** lfn_entry_framer_top: FAILED **");
		$finish;
	end

endmodule
